// File: sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants for the sorted list engine
// Request and result payloads, status and request codes, memory access
// bundle and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    // List sizing
    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DEL_VAL = 2'd1,
        REQ_DEL_POS = 2'd2,
        REQ_DUMP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_LAST,
        ST_DEL_WALK,
        ST_DUMP,
        ST_FINISH
    } t_state;

    // Request payload
    typedef struct packed {
        t_req                      req_type;
        logic signed [DATA_W-1:0]  value;
        logic [4:0]                position;
    } t_in;

    // Result payload
    typedef struct packed {
        t_status                   status;
        logic [4:0]                entry_count;
        logic signed [DATA_W-1:0]  entry_value;
        logic                      last;
    } t_out;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic valid;
        t_out data;
    } t_emit;

    // One read port and one write port on the list storage
    typedef struct packed {
        logic                      re;
        logic [IDX_W-1:0]          raddr;
        logic                      we;
        logic [IDX_W-1:0]          waddr;
        logic signed [DATA_W-1:0]  wdata;
    } t_mem_req;

    // Entry count as it appears on the result (low five bits)
    function automatic logic [4:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
        return 5'(cnt);
    endfunction

endpackage

`default_nettype wire

// File: sv/sle_mem.sv
// ----------------------------------------------------------------------------
// sle_mem: list storage
// Single write port, single read port, read data registered.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_mem (
    input  wire logic                              i_clk,
    input  wire sle_pkg::t_mem_req                 i_req,
    output logic signed [sle_pkg::DATA_W-1:0]      o_rdata
);

    logic signed [sle_pkg::DATA_W-1:0] mem [sle_pkg::CAPACITY];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/sle_seq.sv
// ----------------------------------------------------------------------------
// sle_seq: request sequencer
// Walks the list storage one entry a cycle (a dump waits while results are not taken): shifts up for insert, shifts
// down behind the removed entry for deletes, streams entries for dump.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire sle_pkg::t_in                      i_in,
    output logic                                   o_in_ready,
    input  wire logic                              i_can_load,
    input  wire logic signed [sle_pkg::DATA_W-1:0] i_rdata,
    output sle_pkg::t_mem_req                      o_mem,
    output sle_pkg::t_emit                         o_emit
);

    sle_pkg::t_state                    r_state, n_state;
    logic [sle_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [sle_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [sle_pkg::IDX_W-1:0]          r_lim, n_lim;   // delete target or dump end
    logic signed [sle_pkg::DATA_W-1:0]  r_val, n_val;
    sle_pkg::t_req                      r_req, n_req;
    logic                               r_found, n_found;
    sle_pkg::t_status                   r_status, n_status;

    logic                               hit;
    logic                               walk_end;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_found <= n_found;
        end
    end

    // request context
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_lim    <= n_lim;
        r_val    <= n_val;
        r_req    <= n_req;
        r_status <= n_status;
    end

    // next state, memory accesses and results
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_val      = r_val;
        n_req      = r_req;
        n_found    = r_found;
        n_status   = r_status;
        o_mem      = '0;
        o_emit     = '0;
        o_in_ready = (r_state == sle_pkg::ST_IDLE);
        hit        = 1'b0;
        walk_end   = 1'b0;

        unique case (r_state)
            sle_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_val    = i_in.value;
                    n_req    = i_in.req_type;
                    n_status = sle_pkg::STS_OK;
                    n_found  = 1'b0;
                    unique case (i_in.req_type)
                        sle_pkg::REQ_INSERT: begin
                            if (r_cnt == sle_pkg::CNT_W'(sle_pkg::CAPACITY)) begin
                                n_status = sle_pkg::STS_FULL;
                                n_state  = sle_pkg::ST_FINISH;
                            end else if (r_cnt == '0) begin
                                n_state = sle_pkg::ST_INS_LAST;
                            end else begin
                                // walk down from the top entry
                                o_mem.re    = 1'b1;
                                o_mem.raddr = sle_pkg::IDX_W'(r_cnt - 1'b1);
                                n_idx       = sle_pkg::IDX_W'(r_cnt - 1'b1);
                                n_state     = sle_pkg::ST_INS_WALK;
                            end
                        end
                        sle_pkg::REQ_DEL_VAL: begin
                            if (r_cnt == '0) begin
                                n_status = sle_pkg::STS_EMPTY;
                                n_state  = sle_pkg::ST_FINISH;
                            end else begin
                                o_mem.re = 1'b1;
                                n_idx    = '0;
                                n_state  = sle_pkg::ST_DEL_WALK;
                            end
                        end
                        sle_pkg::REQ_DEL_POS: begin
                            if (r_cnt == '0) begin
                                n_status = sle_pkg::STS_EMPTY;
                                n_state  = sle_pkg::ST_FINISH;
                            end else if (i_in.position == '0 ||
                                         sle_pkg::CMP_W'(i_in.position) >
                                         sle_pkg::CMP_W'(r_cnt)) begin
                                n_status = sle_pkg::STS_NOT_FOUND;
                                n_state  = sle_pkg::ST_FINISH;
                            end else begin
                                o_mem.re = 1'b1;
                                n_idx    = '0;
                                n_lim    = sle_pkg::IDX_W'(i_in.position - 5'd1);
                                n_state  = sle_pkg::ST_DEL_WALK;
                            end
                        end
                        sle_pkg::REQ_DUMP: begin
                            if (r_cnt == '0) begin
                                n_status = sle_pkg::STS_EMPTY;
                                n_state  = sle_pkg::ST_FINISH;
                            end else begin
                                // dump length is capped at the result limit
                                if (sle_pkg::CMP_W'(r_cnt) >
                                    sle_pkg::CMP_W'(sle_pkg::MAX_RESULTS)) begin
                                    n_lim = sle_pkg::IDX_W'(sle_pkg::MAX_RESULTS - 1);
                                end else begin
                                    n_lim = sle_pkg::IDX_W'(r_cnt - 1'b1);
                                end
                                o_mem.re = 1'b1;
                                n_idx    = '0;
                                n_state  = sle_pkg::ST_DUMP;
                            end
                        end
                    endcase
                end
            end

            // entries above the new value move up one slot
            sle_pkg::ST_INS_WALK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx + 1'b1;
                if (i_rdata > r_val) begin
                    o_mem.wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = sle_pkg::ST_INS_LAST;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_idx - 1'b1;
                        n_idx       = r_idx - 1'b1;
                    end
                end else begin
                    o_mem.wdata = r_val;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = sle_pkg::ST_FINISH;
                end
            end

            // new value goes to the bottom slot
            sle_pkg::ST_INS_LAST: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = '0;
                o_mem.wdata = r_val;
                n_cnt       = r_cnt + 1'b1;
                n_state     = sle_pkg::ST_FINISH;
            end

            // find the victim, then copy each later entry one slot down
            sle_pkg::ST_DEL_WALK: begin
                if (r_req == sle_pkg::REQ_DEL_VAL) begin
                    hit = !r_found && (i_rdata == r_val);
                end else begin
                    hit = !r_found && (r_idx == r_lim);
                end
                if (r_found) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx - 1'b1;
                    o_mem.wdata = i_rdata;
                end
                n_found  = r_found || hit;
                walk_end = (sle_pkg::CNT_W'(r_idx) == r_cnt - 1'b1);
                if (walk_end) begin
                    if (n_found) begin
                        n_cnt    = r_cnt - 1'b1;
                        n_status = sle_pkg::STS_OK;
                    end else begin
                        n_status = sle_pkg::STS_NOT_FOUND;
                    end
                    n_state = sle_pkg::ST_FINISH;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx + 1'b1;
                    n_idx       = r_idx + 1'b1;
                end
            end

            // one entry per result; read data holds while stalled
            sle_pkg::ST_DUMP: begin
                if (i_can_load) begin
                    o_emit.valid             = 1'b1;
                    o_emit.data.status       = sle_pkg::STS_OK;
                    o_emit.data.entry_count  = sle_pkg::cnt_to_out(r_cnt);
                    o_emit.data.entry_value  = i_rdata;
                    o_emit.data.last         = (r_idx == r_lim);
                    if (r_idx == r_lim) begin
                        n_state = sle_pkg::ST_IDLE;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_idx + 1'b1;
                        n_idx       = r_idx + 1'b1;
                    end
                end
            end

            // single status result
            sle_pkg::ST_FINISH: begin
                if (i_can_load) begin
                    o_emit.valid             = 1'b1;
                    o_emit.data.status       = r_status;
                    o_emit.data.entry_count  = sle_pkg::cnt_to_out(r_cnt);
                    o_emit.data.entry_value  = '0;
                    o_emit.data.last         = 1'b1;
                    n_state                  = sle_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sorted_list_engine_unit.sv
// Insert: each entry above the new value moves up one slot, then the new value is written and the result given.
// Delete by value or position: walks every entry in the list, then gives the result.
// Full, empty or bad-position requests: go straight to the finish state for their result.
// Dump: streams entries from the bottom slot up, one entry per cycle if taken.
// One request at a time; the next is taken the cycle after the last result enters the output register.
// Reset clears the entry count and the output valid flag; list storage is not cleared.
// ----------------------------------------------------------------------------
// sorted_list_engine_unit: bounded ascending list of signed words
// Sequencer over a one-port-read, one-port-write list RAM, with an output
// register that lets a finished result wait while the next request enters.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sle_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output sle_pkg::t_out       o_out_data
);

    sle_pkg::t_mem_req                  mem_req;
    logic signed [sle_pkg::DATA_W-1:0]  mem_rdata;
    sle_pkg::t_emit                     emit;
    logic                               can_load;

    logic                               r_out_valid;
    sle_pkg::t_out                      r_out_data;

    // list storage
    sle_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // request sequencer
    sle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .o_in_ready (o_in_ready),
        .i_can_load (can_load),
        .i_rdata    (mem_rdata),
        .o_mem      (mem_req),
        .o_emit     (emit)
    );

    // output register
    assign can_load = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && emit.valid) begin
            r_out_data <= emit.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // sequencer only hands over a result when the output register can take it
    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit.valid |-> can_load)
        else $error("result emitted with output register full");

    // an accepted request always takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer still idle after accepting a request");

    // no result while idle
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !emit.valid)
        else $error("result emitted while idle");

    // storage writes stay inside the list
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (32'(mem_req.waddr) < 32'(sle_pkg::CAPACITY)))
        else $error("write beyond list capacity");
`endif

endmodule

`default_nettype wire
